// ----- rtl/core/command_line_tokenizer_unit_macros.svh -----
// Assertion macros for the command line tokenizer.
// Used by command_line_tokenizer_unit; expects clk_i and rst_ni in scope.
`ifndef COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define CLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define CLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/cltok_pkg.sv -----
// Shared constants for the command line tokenizer: parse modes,
// character codes and parameter defaults. No dependencies.
package cltok_pkg;

  localparam int unsigned MaxTokensDefault = 15;

  localparam int unsigned CharW  = 8;
  localparam int unsigned IndexW = 4;
  localparam int unsigned ModeW  = 2;

  // parse modes
  localparam logic [ModeW-1:0] ModeWs     = 2'd0;
  localparam logic [ModeW-1:0] ModeToken  = 2'd1;
  localparam logic [ModeW-1:0] ModeString = 2'd2;
  localparam logic [ModeW-1:0] ModeEscape = 2'd3;

  // character codes
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChSemi  = 8'h3b;
  localparam logic [CharW-1:0] ChQuote = 8'h22;
  localparam logic [CharW-1:0] ChBslash = 8'h5c;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;

endpackage

// ----- rtl/core/command_line_tokenizer_unit.sv -----
// Command line tokenizer: one byte in, one result out per transaction.
// Input register, then result register; throughput one byte per cycle while
// the output is not stalled by out_ready_i.
// Reset (rst_ni low, asynchronous) empties both registers, returns the parse
// mode and saved mode to whitespace and clears token count and overflow.
// Depends on cltok_pkg and command_line_tokenizer_unit_macros.svh.
`include "command_line_tokenizer_unit_macros.svh"

module command_line_tokenizer_unit #(
  parameter int unsigned MaxTokens = cltok_pkg::MaxTokensDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cltok_pkg::CharW-1:0]    char_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           keep_char_o,
  output logic                           token_start_o,
  output logic [cltok_pkg::IndexW-1:0]   token_index_o,
  output logic                           command_end_o,
  output logic [cltok_pkg::IndexW-1:0]   token_count_o,
  output logic                           too_many_tokens_o
);

  localparam int unsigned CntW = $clog2(MaxTokens + 1);
  localparam int unsigned ExtW = (CntW > cltok_pkg::IndexW) ? CntW : cltok_pkg::IndexW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxTokens);

  // input register
  logic                        in_vld_q;
  logic [cltok_pkg::CharW-1:0] char_q;

  // parse state
  logic [cltok_pkg::ModeW-1:0] mode_q, mode_d;
  logic [cltok_pkg::ModeW-1:0] saved_q, saved_d;
  logic [CntW-1:0]             tokens_q, tokens_d;
  logic                        ovf_q, ovf_d;

  // result register
  logic                        out_vld_q;
  logic                        keep_q, start_q, cend_q, tmt_q;
  logic [cltok_pkg::IndexW-1:0] idx_q, cnt_q;

  logic adv;
  logic keep, start, cend, try_start;
  logic [CntW-1:0] tok_nxt, idx_full;
  logic            ovf_nxt;
  logic [ExtW-1:0] idx_ext, cnt_ext;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_comb begin
    keep      = 1'b0;
    start     = 1'b0;
    cend      = 1'b0;
    try_start = 1'b0;
    mode_d    = mode_q;
    saved_d   = saved_q;
    if (char_q == cltok_pkg::ChNul ||
        (char_q == cltok_pkg::ChSemi && mode_q != cltok_pkg::ModeString &&
         mode_q != cltok_pkg::ModeEscape)) begin
      cend = 1'b1;
    end else begin
      unique case (mode_q)
        cltok_pkg::ModeEscape: begin
          keep   = 1'b1;
          mode_d = saved_q;
        end
        cltok_pkg::ModeString: begin
          if (char_q == cltok_pkg::ChQuote) begin
            mode_d = cltok_pkg::ModeWs;
          end else begin
            keep = 1'b1;
          end
        end
        default: begin
          if (char_q == cltok_pkg::ChSpace || char_q == cltok_pkg::ChTab) begin
            mode_d = cltok_pkg::ModeWs;
          end else if (char_q == cltok_pkg::ChQuote) begin
            try_start = 1'b1;
            mode_d    = cltok_pkg::ModeString;
          end else if (char_q == cltok_pkg::ChBslash) begin
            keep    = 1'b1;
            saved_d = mode_q;
            mode_d  = cltok_pkg::ModeEscape;
          end else begin
            keep      = 1'b1;
            try_start = (mode_q == cltok_pkg::ModeWs);
            mode_d    = cltok_pkg::ModeToken;
          end
        end
      endcase
    end

    // token bound: refused starts only raise the overflow flag
    tok_nxt = tokens_q;
    ovf_nxt = ovf_q;
    if (try_start) begin
      if (tokens_q < MaxCnt) begin
        tok_nxt = tokens_q + CntW'(1);
        start   = 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    idx_full = (tok_nxt != '0) ? (tok_nxt - CntW'(1)) : '0;
    idx_ext  = ExtW'(idx_full);
    cnt_ext  = ExtW'(tok_nxt);

    // command end returns the parse state (modes, token count, overflow) to reset values
    if (cend) begin
      mode_d   = cltok_pkg::ModeWs;
      saved_d  = cltok_pkg::ModeWs;
      tokens_d = '0;
      ovf_d    = 1'b0;
    end else begin
      tokens_d = tok_nxt;
      ovf_d    = ovf_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= cltok_pkg::ModeWs;
      saved_q   <= cltok_pkg::ModeWs;
      tokens_q  <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        mode_q    <= mode_d;
        saved_q   <= saved_d;
        tokens_q  <= tokens_d;
        ovf_q     <= ovf_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
    end
    if (adv) begin
      keep_q  <= keep;
      start_q <= start;
      cend_q  <= cend;
      tmt_q   <= ovf_nxt;
      idx_q   <= idx_ext[cltok_pkg::IndexW-1:0];
      cnt_q   <= cnt_ext[cltok_pkg::IndexW-1:0];
    end
  end

  assign out_valid_o       = out_vld_q;
  assign keep_char_o       = keep_q;
  assign token_start_o     = start_q;
  assign token_index_o     = idx_q;
  assign command_end_o     = cend_q;
  assign token_count_o     = cnt_q;
  assign too_many_tokens_o = tmt_q;

  `CLT_ASSERT(a_cend_clears,
              adv && cend |=> tokens_q == '0 && ovf_q == 1'b0 && mode_q == cltok_pkg::ModeWs,
              "state not cleared after command end")
  `CLT_ASSERT(a_count_bound, tokens_q <= MaxCnt, "token count beyond bound")
  `CLT_ASSERT(a_cend_no_keep, out_vld_q && cend_q |-> !keep_q && !start_q,
              "command end byte kept or started a token")
  `CLT_ASSERT(a_start_index,
              out_vld_q && start_q |-> cnt_q == idx_q + cltok_pkg::IndexW'(1),
              "token index does not match count on start")

endmodule
